[src/v2n_pkg.sv]
package v2n_pkg;

   localparam int OUT_W = 32;

   localparam logic [32:0] SAT_POS = 33'h0_7FFF_FFFF;
   localparam logic [32:0] SAT_NEG = 33'h0_8000_0000;
   localparam logic [32:0] MAG_MAX = 33'h0_FFFF_FFFF;

endpackage

[src/v2n_div.sv]
module v2n_div #(
   parameter int NW     = 64,
   parameter int QB     = 61,
   parameter int STAGES = 61
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num,
   input  logic [NW-1:0] den,
   output logic [QB-1:0] quo
);

   logic [NW-1:0] rem_ff [STAGES];
   logic [NW-1:0] den_ff [STAGES];
   logic [QB-1:0] quo_ff [STAGES];

   for (genvar k = 0; k < STAGES; k++) begin : g_step
      logic [NW-1:0] rem_in;
      logic [NW-1:0] den_in;
      logic [QB-1:0] quo_in;

      if (k == 0) begin : g_first
         logic [NW:0] trial;
         logic        ge;
         always_comb begin
            trial  = {1'b0, num};
            ge     = trial >= {1'b0, den};
            rem_in = ge ? NW'(trial - {1'b0, den}) : num;
            den_in = den;
            quo_in = {{(QB-1){1'b0}}, ge};
         end
      end else if (k < QB) begin : g_mid
         logic [NW:0] trial;
         logic        ge;
         always_comb begin
            trial  = {rem_ff[k-1], 1'b0};
            ge     = trial >= {1'b0, den_ff[k-1]};
            rem_in = ge ? NW'(trial - {1'b0, den_ff[k-1]}) : NW'(trial);
            den_in = den_ff[k-1];
            quo_in = {quo_ff[k-1][QB-2:0], ge};
         end
      end else begin : g_pass
         always_comb begin
            rem_in = rem_ff[k-1];
            den_in = den_ff[k-1];
            quo_in = quo_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_in;
            quo_ff[k] <= quo_in;
         end
      end
   end

   assign quo = quo_ff[STAGES-1];

endmodule

[src/v2n_isqrt.sv]
module v2n_isqrt #(
   parameter int RW     = 32,
   parameter int STAGES = 32
) (
   input  logic            clock,
   input  logic            en,
   input  logic [2*RW-1:0] val,
   output logic [RW-1:0]   root
);

   logic [2*RW-1:0] val_ff  [STAGES];
   logic [RW+1:0]   rem_ff  [STAGES];
   logic [RW-1:0]   root_ff [STAGES];

   for (genvar k = 0; k < STAGES; k++) begin : g_step
      logic [2*RW-1:0] val_prev;
      logic [RW+1:0]   rem_prev;
      logic [RW-1:0]   root_prev;
      logic [2*RW-1:0] val_in;
      logic [RW+1:0]   rem_in;
      logic [RW-1:0]   root_in;

      if (k == 0) begin : g_src_in
         always_comb begin
            val_prev  = val;
            rem_prev  = '0;
            root_prev = '0;
         end
      end else begin : g_src_reg
         always_comb begin
            val_prev  = val_ff[k-1];
            rem_prev  = rem_ff[k-1];
            root_prev = root_ff[k-1];
         end
      end

      if (k < RW) begin : g_work
         logic [RW+3:0] cat;
         logic [RW+3:0] trial;
         logic          ge;
         always_comb begin
            cat     = {rem_prev, val_prev[2*RW-1 -: 2]};
            trial   = {2'b00, root_prev, 2'b01};
            ge      = cat >= trial;
            rem_in  = ge ? (RW+2)'(cat - trial) : (RW+2)'(cat);
            root_in = {root_prev[RW-2:0], ge};
            val_in  = {val_prev[2*RW-3:0], 2'b00};
         end
      end else begin : g_pass
         always_comb begin
            rem_in  = rem_prev;
            root_in = root_prev;
            val_in  = val_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            val_ff[k]  <= val_in;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
         end
      end
   end

   assign root = root_ff[STAGES-1];

endmodule

[src/vec2_normalize_top.sv]
// Normalizes a 2D vector. A beat on the req_ channel carries vec_x and
// vec_y as signed Q16.16 values. For each request beat exactly one beat
// leaves on the rsp_ channel, in order, with the truncated Euclidean length
// (unsigned Q16.16), the unit vector (signed, OUT_FRAC_BITS fraction bits,
// truncated toward zero) and was_zero, which is set for a zero input whose
// other fields are then all zero.
// The pipeline depth is set by the restoring divider, which retires one
// quotient bit per stage, followed by the square root stages, which retire
// one root bit per stage.
// Throughput is one beat per cycle. The pipeline advances as a whole:
// while a response beat is held by a low rsp_ready, req_ready is low and
// every stage holds its contents; nothing is lost or repeated.
// Reset clears all valid bits, so no response beat is shown after reset
// until a request has gone through the pipeline.
module vec2_normalize_top #(
   parameter int COORD_WIDTH   = 32,
   parameter int OUT_FRAC_BITS = 30
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [COORD_WIDTH-1:0]  req_vec_x,
   input  logic signed [COORD_WIDTH-1:0]  req_vec_y,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [v2n_pkg::OUT_W-1:0] rsp_unit_x,
   output logic signed [v2n_pkg::OUT_W-1:0] rsp_unit_y,
   output logic [v2n_pkg::OUT_W-1:0]      rsp_magnitude,
   output logic                           rsp_was_zero
);

   import v2n_pkg::*;

   localparam int CW  = COORD_WIDTH;
   localparam int F   = OUT_FRAC_BITS;
   localparam int SW  = 2 * CW;
   localparam int QB  = 2 * F + 1;
   localparam int L1  = (QB > CW) ? QB : CW;
   localparam int L2  = F + 1;
   localparam int NV  = 4 + L1 + L2;
   localparam int EW  = (F + 1 > 33) ? F + 1 : 33;
   localparam int MW  = (CW + 1 > 33) ? CW + 1 : 33;

   logic          adv;
   logic [NV-1:0] valid_ff;
   logic [NV-1:0] valid_in;

   assign adv       = !valid_ff[NV-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = valid_ff[NV-1];
   assign valid_in  = {valid_ff[NV-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   logic [CW-1:0] ax_ff, ay_ff;
   logic          nx_ff, ny_ff;
   logic [SW-1:0] sx_ff, sy_ff;
   logic          nx1_ff, ny1_ff, zero1_ff;
   logic [SW-1:0] sum_ff, sx2_ff, sy2_ff;
   logic          nx2_ff, ny2_ff, zero2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         nx_ff    <= req_vec_x[CW-1];
         ny_ff    <= req_vec_y[CW-1];
         ax_ff    <= req_vec_x[CW-1] ? CW'(~req_vec_x + 1'b1) : CW'(req_vec_x);
         ay_ff    <= req_vec_y[CW-1] ? CW'(~req_vec_y + 1'b1) : CW'(req_vec_y);
         sx_ff    <= SW'(ax_ff) * SW'(ax_ff);
         sy_ff    <= SW'(ay_ff) * SW'(ay_ff);
         nx1_ff   <= nx_ff;
         ny1_ff   <= ny_ff;
         zero1_ff <= (ax_ff == '0) && (ay_ff == '0);
         sum_ff   <= sx_ff + sy_ff;
         sx2_ff   <= sx_ff;
         sy2_ff   <= sy_ff;
         nx2_ff   <= nx1_ff;
         ny2_ff   <= ny1_ff;
         zero2_ff <= zero1_ff;
      end
   end

   logic [QB-1:0] qx, qy;
   logic [CW-1:0] mag;

   v2n_div #(.NW(SW), .QB(QB), .STAGES(L1)) u_div_x (
      .clock(clock), .en(adv), .num(sx2_ff), .den(sum_ff), .quo(qx)
   );

   v2n_div #(.NW(SW), .QB(QB), .STAGES(L1)) u_div_y (
      .clock(clock), .en(adv), .num(sy2_ff), .den(sum_ff), .quo(qy)
   );

   v2n_isqrt #(.RW(CW), .STAGES(L1)) u_sqrt_mag (
      .clock(clock), .en(adv), .val(sum_ff), .root(mag)
   );

   logic [2:0] side1_ff [L1];

   for (genvar k = 0; k < L1; k++) begin : g_side1
      always_ff @(posedge clock) begin
         if (adv) begin
            if (k == 0) begin
               side1_ff[k] <= {zero2_ff, nx2_ff, ny2_ff};
            end else begin
               side1_ff[k] <= side1_ff[k-1];
            end
         end
      end
   end

   logic [F:0] rx, ry;

   v2n_isqrt #(.RW(F + 1), .STAGES(L2)) u_sqrt_x (
      .clock(clock), .en(adv), .val({1'b0, qx}), .root(rx)
   );

   v2n_isqrt #(.RW(F + 1), .STAGES(L2)) u_sqrt_y (
      .clock(clock), .en(adv), .val({1'b0, qy}), .root(ry)
   );

   logic [CW+2:0] side2_ff [L2];

   for (genvar k = 0; k < L2; k++) begin : g_side2
      always_ff @(posedge clock) begin
         if (adv) begin
            if (k == 0) begin
               side2_ff[k] <= {side1_ff[L1-1], mag};
            end else begin
               side2_ff[k] <= side2_ff[k-1];
            end
         end
      end
   end

   logic          zero_s, nx_s, ny_s;
   logic [CW-1:0] mag_s;
   logic [EW-1:0] qx_w, qy_w;
   logic [MW-1:0] mag_w;
   logic [OUT_W-1:0] ux_in, uy_in, mag_in;

   always_comb begin
      {zero_s, nx_s, ny_s, mag_s} = side2_ff[L2-1];
      qx_w  = EW'(rx);
      qy_w  = EW'(ry);
      mag_w = MW'(mag_s);
      if (nx_s) begin
         if (qx_w > EW'(SAT_NEG)) qx_w = EW'(SAT_NEG);
         ux_in = OUT_W'(0) - qx_w[OUT_W-1:0];
      end else begin
         if (qx_w > EW'(SAT_POS)) qx_w = EW'(SAT_POS);
         ux_in = qx_w[OUT_W-1:0];
      end
      if (ny_s) begin
         if (qy_w > EW'(SAT_NEG)) qy_w = EW'(SAT_NEG);
         uy_in = OUT_W'(0) - qy_w[OUT_W-1:0];
      end else begin
         if (qy_w > EW'(SAT_POS)) qy_w = EW'(SAT_POS);
         uy_in = qy_w[OUT_W-1:0];
      end
      if (mag_w > MW'(MAG_MAX)) mag_w = MW'(MAG_MAX);
      mag_in = mag_w[OUT_W-1:0];
      if (zero_s) begin
         ux_in  = '0;
         uy_in  = '0;
         mag_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_unit_x    <= ux_in;
         rsp_unit_y    <= uy_in;
         rsp_magnitude <= mag_in;
         rsp_was_zero  <= zero_s;
      end
   end

endmodule

[src/v2n_check.sv]
module v2n_check (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [v2n_pkg::OUT_W-1:0] rsp_unit_x,
   input logic [v2n_pkg::OUT_W-1:0] rsp_unit_y,
   input logic [v2n_pkg::OUT_W-1:0] rsp_magnitude,
   input logic                     rsp_was_zero
);

   import v2n_pkg::*;

   // A held response beat keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_unit_x)
         && $stable(rsp_unit_y) && $stable(rsp_magnitude) && $stable(rsp_was_zero))
      else $error("response beat changed while stalled");

   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_zero |-> rsp_magnitude == '0 && rsp_unit_x == '0
         && rsp_unit_y == '0)
      else $error("zero vector with nonzero fields");

   a_nonzero_mag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_was_zero |-> rsp_magnitude != '0)
      else $error("nonzero vector with zero length");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("input stalled with free output");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response beat after reset");

endmodule

bind vec2_normalize_top v2n_check u_v2n_check (
   .clock(clock),
   .reset(reset),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_unit_x(rsp_unit_x),
   .rsp_unit_y(rsp_unit_y),
   .rsp_magnitude(rsp_magnitude),
   .rsp_was_zero(rsp_was_zero)
);

[tb/vec2_normalize_top_tb.sv]
`timescale 1ns / 1ps

module vec2_normalize_top_tb;

   typedef struct {
      logic signed [31:0] unit_x;
      logic signed [31:0] unit_y;
      logic [31:0]        magnitude;
      logic               was_zero;
   } norm_result_type;

   class norm_scoreboard;
      norm_result_type pending[$];
      int              errors;
      int              checked;

      function logic [63:0] isqrt_search(input logic [127:0] target,
                                         input logic [127:0] scale, input int top);
         logic [127:0] q;
         logic [127:0] cand;
         q = '0;
         for (int b = top; b >= 0; b--) begin
            cand = q | (128'd1 << b);
            if (cand * cand * scale <= target) q = cand;
         end
         return q[63:0];
      endfunction

      function logic [31:0] to_signed_out(input logic [63:0] q, input logic neg);
         if (neg) begin
            if (q > 64'h8000_0000) q = 64'h8000_0000;
            return 32'(-q);
         end
         if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
         return q[31:0];
      endfunction

      function void note_input(input logic signed [31:0] vx, input logic signed [31:0] vy);
         norm_result_type r;
         logic [63:0]  ax;
         logic [63:0]  ay;
         logic [127:0] sum;
         logic [63:0]  mag;
         ax = vx[31] ? 64'(-64'(vx)) : 64'(vx);
         ay = vy[31] ? 64'(-64'(vy)) : 64'(vy);
         if (ax == 0 && ay == 0) begin
            r.unit_x = 0; r.unit_y = 0; r.magnitude = 0; r.was_zero = 1'b1;
         end else begin
            sum = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
            mag = isqrt_search(sum, 128'd1, 32);
            if (mag > 64'hFFFF_FFFF) mag = 64'hFFFF_FFFF;
            r.magnitude = mag[31:0];
            r.unit_x = to_signed_out(isqrt_search((128'(ax) * 128'(ax)) << 60, sum, 30), vx[31]);
            r.unit_y = to_signed_out(isqrt_search((128'(ay) * 128'(ay)) << 60, sum, 30), vy[31]);
            r.was_zero = 1'b0;
         end
         pending.push_back(r);
      endfunction

      task report(input string what, input logic [31:0] got, input logic [31:0] want);
         $display("mismatch on %s: got %h, expected %h", what, got, want);
         errors++;
      endtask

      task check_result(input norm_result_type got);
         norm_result_type want;
         checked++;
         if (pending.size() == 0) begin
            report("unexpected response beat", 0, 0);
            return;
         end
         want = pending.pop_front();
         if (got.unit_x !== want.unit_x) report("unit_x", got.unit_x, want.unit_x);
         if (got.unit_y !== want.unit_y) report("unit_y", got.unit_y, want.unit_y);
         if (got.magnitude !== want.magnitude)
            report("magnitude", got.magnitude, want.magnitude);
         if (got.was_zero !== want.was_zero)
            report("was_zero", 32'(got.was_zero), 32'(want.was_zero));
      endtask
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [31:0] req_vec_x;
   logic signed [31:0] req_vec_y;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_unit_x;
   logic signed [31:0] rsp_unit_y;
   logic [31:0]        rsp_magnitude;
   logic               rsp_was_zero;

   norm_scoreboard sb;
   bit             busy_phase;
   int             sent;

   vec2_normalize_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_vec_x(req_vec_x), .req_vec_y(req_vec_y),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_unit_x(rsp_unit_x), .rsp_unit_y(rsp_unit_y),
      .rsp_magnitude(rsp_magnitude), .rsp_was_zero(rsp_was_zero)
   );

   always begin
      clock = 1'b1; #10;
      clock = 1'b0; #10;
   end

   task send_vector(input logic [31:0] vx, input logic [31:0] vy);
      int gap;
      gap = busy_phase ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_vec_x <= vx;
      req_vec_y <= vy;
      do @(posedge clock); while (!req_ready);
      sb.note_input(vx, vy);
      sent++;
   endtask

   task send_random_vector();
      logic [31:0] vx;
      logic [31:0] vy;
      vx = $urandom;
      vy = $urandom;
      case ($urandom_range(0, 5))
         0: begin vx = $signed(vx) >>> $urandom_range(0, 31); vy = $signed(vy) >>> $urandom_range(0, 31); end
         1: vx = 0;
         2: vy = 0;
         3: begin vx = $urandom_range(0, 3) - 2; vy = $urandom_range(0, 3) - 2; end
         default: ;
      endcase
      send_vector(vx, vy);
   endtask

   initial begin : response_side
      norm_result_type r;
      int              stall;
      rsp_ready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = busy_phase ? 0 : $urandom_range(0, 8);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         r.unit_x = rsp_unit_x;
         r.unit_y = rsp_unit_y;
         r.magnitude = rsp_magnitude;
         r.was_zero = rsp_was_zero;
         sb.check_result(r);
      end
   end

   initial begin : watchdog
      #5ms;
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      int wait_cycles;
      sb = new();
      busy_phase = 0;
      sent = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_vec_x <= '0;
      req_vec_y <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_vector(32'h0000_0000, 32'h0000_0000);
      send_vector(32'h0001_0000, 32'h0000_0000);
      send_vector(32'hFFFF_0000, 32'h0000_0000);
      send_vector(32'h0000_0000, 32'h0001_0000);
      send_vector(32'h0000_0000, 32'hFFFF_0000);
      send_vector(32'h0000_0001, 32'h0000_0000);
      send_vector(32'h0000_0000, 32'hFFFF_FFFF);
      send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_vector(32'h8000_0000, 32'h8000_0000);
      send_vector(32'h8000_0000, 32'h7FFF_FFFF);
      send_vector(32'h7FFF_FFFF, 32'h8000_0000);
      send_vector(32'h8000_0000, 32'h0000_0000);
      send_vector(32'h0000_0000, 32'h7FFF_FFFF);
      send_vector(32'h0003_0000, 32'hFFFC_0000);
      send_vector(32'h0000_0001, 32'h0000_0001);
      send_vector(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_vector(32'h0000_0001, 32'h7FFF_FFFF);
      send_vector(32'hAAAA_AAAA, 32'h5555_5555);
      send_vector(32'h5555_5555, 32'hAAAA_AAAA);

      for (int i = 0; i < 950; i++) begin
         if (i % 100 == 0) busy_phase = ($urandom_range(0, 2) == 0);
         send_random_vector();
      end
      req_valid <= 1'b0;

      wait_cycles = 0;
      while (sb.pending.size() != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (200) @(posedge clock);
      $display("Sent %0d vectors including zero, axis and extreme cases; checked %0d results.",
               sent, sb.checked);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches, %0d results missing.", sb.errors, sb.pending.size());
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[files.f]
src/v2n_pkg.sv
src/v2n_div.sv
src/v2n_isqrt.sv
src/vec2_normalize_top.sv
src/v2n_check.sv
tb/vec2_normalize_top_tb.sv
